// File: hw/rtl/mbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart boundary stripper package
// Shared widths, codes, state type and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int OP_W         = 2;
   localparam int DATA_W       = 8;
   localparam int CHAR_INDEX_W = 6;
   localparam int OUT_ADDR_W   = 24;
   localparam int START_ADDR_W = 24;
   localparam int LENGTH_W     = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_LENGTH = 1'b1;

   localparam logic [LENGTH_W-1:0] BOUNDARY_LENGTH_RESET = 7'd5;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_CHAR = 2'd0,
      OP_START     = 2'd1,
      OP_DATA      = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPLAY_READ,
      ST_REPLAY_EMIT,
      ST_EMIT_BYTE,
      ST_EMIT_END
   } ctrl_state_type;

   typedef struct packed {
      logic load_char;
      logic start_part;
      logic latch_byte;
      logic advance;
      logic replay_clear;
      logic read_replay;
      logic emit_replay;
      logic emit_byte;
      logic emit_end;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            active;
      logic            hit;
      logic            done;
      logic            match_zero;
      logic            replay_last;
      logic            slot_free;
   } ctrl_status_type;

endpackage

// File: hw/rtl/mbs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one input item of the stripper.
// ----------------------------------------------------------------------------
interface mbs_req_if import mbs_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [DATA_W-1:0]       value;
   logic [CHAR_INDEX_W-1:0] char_index;

   modport source (output valid, output operation, output value, output char_index,
                   input ready);
   modport sink   (input valid, input operation, input value, input char_index,
                   output ready);

endinterface

// File: hw/rtl/mbs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one result item of the stripper.
// ----------------------------------------------------------------------------
interface mbs_rsp_if import mbs_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [DATA_W-1:0]     data_byte;
   logic [OUT_ADDR_W-1:0] byte_address;
   logic                  sector_first;
   logic                  page_last;
   logic                  last;

   modport source (output valid, output kind, output data_byte, output byte_address,
                   output sector_first, output page_last, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_address,
                   input sector_first, input page_last, input last, output ready);

endinterface

// File: hw/rtl/mbs_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart boundary stripper controller
// Sequences item intake, boundary compare, prefix replay and result loads.
// ----------------------------------------------------------------------------
module mbs_controller import mbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status_in,
   output ctrl_cmd_type    cmd_out
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (status_in.op)
                  OP_LOAD_CHAR: begin
                     cmd_out.load_char = 1'b1;
                  end
                  OP_START: begin
                     cmd_out.start_part = 1'b1;
                  end
                  OP_DATA: begin
                     if (status_in.active) begin
                        cmd_out.latch_byte = 1'b1;
                        state_in           = ST_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            priority if (status_in.done) begin
               state_in = ST_EMIT_END;
            end else if (status_in.hit) begin
               cmd_out.advance = 1'b1;
               state_in        = ST_IDLE;
            end else if (status_in.match_zero) begin
               state_in = ST_EMIT_BYTE;
            end else begin
               cmd_out.replay_clear = 1'b1;
               state_in             = ST_REPLAY_READ;
            end
         end
         ST_REPLAY_READ: begin
            cmd_out.read_replay = 1'b1;
            state_in            = ST_REPLAY_EMIT;
         end
         ST_REPLAY_EMIT: begin
            if (status_in.slot_free) begin
               cmd_out.emit_replay = 1'b1;
               state_in = status_in.replay_last ? ST_EMIT_BYTE : ST_REPLAY_READ;
            end
         end
         ST_EMIT_BYTE: begin
            if (status_in.slot_free) begin
               cmd_out.emit_byte = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_EMIT_END: begin
            if (status_in.slot_free) begin
               cmd_out.emit_end = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/mbs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart boundary stripper datapath
// Boundary memory, match and address counters, settings and result register.
// ----------------------------------------------------------------------------
module mbs_datapath import mbs_pkg::*; #(
   parameter int BOUNDARY_DEPTH = 64,
   parameter int PAGE_SIZE      = 256,
   parameter int SECTOR_SIZE    = 4096,
   parameter int ADDRESS_WIDTH  = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [DATA_W-1:0]       req_value,
   input  logic [CHAR_INDEX_W-1:0] req_char_index,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic [DATA_W-1:0]       rsp_data_byte,
   output logic [OUT_ADDR_W-1:0]   rsp_byte_address,
   output logic                    rsp_sector_first,
   output logic                    rsp_page_last,
   output logic                    rsp_last,
   input  ctrl_cmd_type            cmd_in,
   output ctrl_status_type         status_out
);

   localparam int IDX_W       = $clog2(BOUNDARY_DEPTH);
   localparam int LEN_W       = $clog2(BOUNDARY_DEPTH + 1);
   localparam int PAGE_BITS   = $clog2(PAGE_SIZE);
   localparam int SECTOR_BITS = $clog2(SECTOR_SIZE);
   localparam int ADDR_EXT_W  = ADDRESS_WIDTH + OUT_ADDR_W;

   logic [DATA_W-1:0]        store_mem [BOUNDARY_DEPTH];
   logic [DATA_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;

   logic [START_ADDR_W-1:0]  start_addr_ff, start_addr_in;
   logic [LENGTH_W-1:0]      blen_ff, blen_in;
   logic                     active_ff, active_in;
   logic [LEN_W-1:0]         match_ff, match_in;
   logic [LEN_W-1:0]         replay_ff, replay_in;
   logic [ADDRESS_WIDTH-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0]        val_ff, val_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_kind_ff, out_kind_in;
   logic [DATA_W-1:0]        out_data_ff, out_data_in;
   logic [OUT_ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic                     out_sf_ff, out_sf_in;
   logic                     out_pl_ff, out_pl_in;
   logic                     out_last_ff, out_last_in;

   logic [LEN_W-1:0]         used_len;
   logic [LEN_W:0]           match_inc;
   logic [LEN_W:0]           replay_inc;
   logic [ADDR_EXT_W-1:0]    start_ext;
   logic [ADDR_EXT_W-1:0]    addr_ext;
   logic                     hit;
   logic                     done;
   logic                     slot_free;
   logic                     load_ok;
   logic                     emit_any;

   always_comb begin
      if (blen_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (int'(blen_ff) > BOUNDARY_DEPTH) begin
         used_len = LEN_W'(BOUNDARY_DEPTH);
      end else begin
         used_len = LEN_W'(blen_ff);
      end
   end

   assign match_inc  = {1'b0, match_ff} + 1'b1;
   assign replay_inc = {1'b0, replay_ff} + 1'b1;
   assign start_ext  = ADDR_EXT_W'(start_addr_ff);
   assign addr_ext   = ADDR_EXT_W'(addr_ff);
   assign hit        = (match_ff < used_len) && (val_ff == rd_data_ff);
   assign done       = hit ? (match_inc >= {1'b0, used_len}) : (match_ff >= used_len);
   assign slot_free  = !out_valid_ff || rsp_ready;
   assign load_ok    = int'(req_char_index) < BOUNDARY_DEPTH;
   assign emit_any   = cmd_in.emit_replay || cmd_in.emit_byte || cmd_in.emit_end;

   assign status_out.op          = req_operation;
   assign status_out.active      = active_ff;
   assign status_out.hit         = hit;
   assign status_out.done        = done;
   assign status_out.match_zero  = (match_ff == '0);
   assign status_out.replay_last = (replay_inc >= {1'b0, match_ff});
   assign status_out.slot_free   = slot_free;

   assign rd_en   = cmd_in.latch_byte || cmd_in.read_replay;
   assign rd_addr = cmd_in.read_replay ? replay_ff[IDX_W-1:0] : match_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd_in.load_char && load_ok) begin
         store_mem[IDX_W'(req_char_index)] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      start_addr_in = start_addr_ff;
      blen_in       = blen_ff;
      active_in     = active_ff;
      match_in      = match_ff;
      replay_in     = replay_ff;
      addr_in       = addr_ff;
      val_in        = val_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_data_in   = out_data_ff;
      out_addr_in   = out_addr_ff;
      out_sf_in     = out_sf_ff;
      out_pl_in     = out_pl_ff;
      out_last_in   = out_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_ADDRESS: begin
               start_addr_in = csr_wdata[START_ADDR_W-1:0];
            end
            CSR_BOUNDARY_LENGTH: begin
               blen_in = csr_wdata[LENGTH_W-1:0];
            end
         endcase
      end

      if (cmd_in.start_part) begin
         match_in  = '0;
         addr_in   = start_ext[ADDRESS_WIDTH-1:0];
         active_in = 1'b1;
      end
      if (cmd_in.latch_byte) begin
         val_in = req_value;
      end
      if (cmd_in.advance) begin
         match_in = match_inc[LEN_W-1:0];
      end
      if (cmd_in.replay_clear) begin
         replay_in = '0;
      end

      if (emit_any) begin
         out_valid_in = 1'b1;
         out_addr_in  = addr_ext[OUT_ADDR_W-1:0];
         out_sf_in    = (addr_ff[SECTOR_BITS-1:0] == '0);
         out_pl_in    = &addr_ff[PAGE_BITS-1:0];
         out_kind_in  = KIND_DATA;
         out_last_in  = 1'b0;
      end
      if (cmd_in.emit_replay) begin
         out_data_in = rd_data_ff;
         addr_in     = addr_ff + 1'b1;
         replay_in   = replay_inc[LEN_W-1:0];
      end
      if (cmd_in.emit_byte) begin
         out_data_in = val_ff;
         out_last_in = 1'b1;
         addr_in     = addr_ff + 1'b1;
         match_in    = '0;
      end
      if (cmd_in.emit_end) begin
         out_kind_in = KIND_END;
         out_data_in = '0;
         out_sf_in   = 1'b0;
         out_pl_in   = 1'b0;
         out_last_in = 1'b1;
         match_in    = '0;
         active_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         blen_ff       <= BOUNDARY_LENGTH_RESET;
         active_ff     <= 1'b0;
         match_ff      <= '0;
         replay_ff     <= '0;
         addr_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         start_addr_ff <= start_addr_in;
         blen_ff       <= blen_in;
         active_ff     <= active_in;
         match_ff      <= match_in;
         replay_ff     <= replay_in;
         addr_ff       <= addr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_addr_ff <= out_addr_in;
      out_sf_ff   <= out_sf_in;
      out_pl_ff   <= out_pl_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_sector_first = out_sf_ff;
   assign rsp_page_last    = out_pl_ff;
   assign rsp_last         = out_last_ff;

   // A result is loaded only into a free slot, and at most one per cycle.
   assert property (@(posedge clock) disable iff (reset) emit_any |-> slot_free)
      else $error("result loaded while the output slot is occupied");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd_in.emit_replay, cmd_in.emit_byte, cmd_in.emit_end}))
      else $error("more than one result load in a cycle");

   assert property (@(posedge clock) disable iff (reset) cmd_in.emit_end |=> !active_ff)
      else $error("part still active after its end item");

   assert property (@(posedge clock) disable iff (reset) cmd_in.emit_byte |=> match_ff == '0)
      else $error("match not cleared after a mismatching byte");

   assert property (@(posedge clock) disable iff (reset)
      cmd_in.emit_replay |-> replay_ff < match_ff)
      else $error("replay ran past the held prefix");

endmodule

// File: hw/rtl/multipart_boundary_stripper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multipart boundary stripper core
// Passes upload bytes on as addressed flash bytes and removes the end boundary.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Boundary loads and start items are done
// in the cycle they are taken in. A data byte that extends the boundary match
// passes the check state, since the boundary character comes from a memory
// with a registered read. A byte that breaks a match of m characters first
// replays them (a read state and a load state each), then is loaded itself.
// A completing byte passes the check state and loads the end result. Stalls
// of the result channel hold each load. There is no clearing pass after reset.
module multipart_boundary_stripper_core import mbs_pkg::*; #(
   parameter int BOUNDARY_DEPTH = 64,
   parameter int PAGE_SIZE      = 256,
   parameter int SECTOR_SIZE    = 4096,
   parameter int ADDRESS_WIDTH  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   mbs_req_if.sink                req_ch,
   mbs_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status_in (status),
      .cmd_out   (cmd)
   );

   mbs_datapath #(
      .BOUNDARY_DEPTH (BOUNDARY_DEPTH),
      .PAGE_SIZE      (PAGE_SIZE),
      .SECTOR_SIZE    (SECTOR_SIZE),
      .ADDRESS_WIDTH  (ADDRESS_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_ch.operation),
      .req_value        (req_ch.value),
      .req_char_index   (req_ch.char_index),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_kind         (rsp_ch.kind),
      .rsp_data_byte    (rsp_ch.data_byte),
      .rsp_byte_address (rsp_ch.byte_address),
      .rsp_sector_first (rsp_ch.sector_first),
      .rsp_page_last    (rsp_ch.page_last),
      .rsp_last         (rsp_ch.last),
      .cmd_in           (cmd),
      .status_out       (status)
   );

endmodule

// File: test/tb_multipart_boundary_stripper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multipart boundary stripper core
// A short directed table covers idle and unused items, boundary loads, single
// byte output, prefix replay, a completed boundary and restarts. Random parts
// follow under several address and length settings, including wrap, a zero
// length and a length lowered in the middle of a match. Every result is
// checked in order against an independent prediction of the stripper.
// ----------------------------------------------------------------------------
module tb_multipart_boundary_stripper_core;
   import mbs_pkg::*;

   localparam int PAGE_BYTES    = 256;
   localparam int SECTOR_BYTES  = 4096;
   localparam int STORE_DEPTH   = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEM_TARGET   = 125;
   localparam int QUIET_ITEMS   = 30;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] CHK_PREDICTED = 2'd0;
   localparam logic [1:0] CHK_SILENT    = 2'd1;
   localparam logic [1:0] CHK_TYPED     = 2'd2;

   localparam logic [31:0] CRLF_DASH = 32'h0D0A2D2D;

   typedef struct packed {
      logic                  kind;
      logic [DATA_W-1:0]     data_byte;
      logic [OUT_ADDR_W-1:0] byte_address;
      logic                  sector_first;
      logic                  page_last;
      logic                  last;
   } flash_beat_type;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [DATA_W-1:0]       value;
      logic [CHAR_INDEX_W-1:0] char_index;
      logic [1:0]              chk;
      flash_beat_type          beat;
   } stim_row_type;

   localparam flash_beat_type NO_BEAT = '0;
   localparam int DIR_ROWS = 26;

   stim_row_type dir_tab [DIR_ROWS] = '{
      '{OP_UNUSED,    8'hFF, 6'd63, CHK_SILENT,    NO_BEAT},
      '{OP_DATA,      8'h41, 6'd0,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h0D, 6'd0,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h0A, 6'd1,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h2D, 6'd2,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h2D, 6'd3,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h41, 6'd4,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'h00, 6'd5,  CHK_SILENT,    NO_BEAT},
      '{OP_LOAD_CHAR, 8'hFF, 6'd63, CHK_SILENT,    NO_BEAT},
      '{OP_START,     8'h00, 6'd0,  CHK_SILENT,    NO_BEAT},
      '{OP_DATA,      8'h00, 6'd0,  CHK_TYPED,
        '{KIND_DATA, 8'h00, 24'h000000, 1'b1, 1'b0, 1'b1}},
      '{OP_DATA,      8'hFF, 6'd63, CHK_TYPED,
        '{KIND_DATA, 8'hFF, 24'h000001, 1'b0, 1'b0, 1'b1}},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h0A, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h58, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h0A, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h2D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h2D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h41, 6'd0,  CHK_TYPED,
        '{KIND_END, 8'h00, 24'h000005, 1'b0, 1'b0, 1'b1}},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_SILENT,    NO_BEAT},
      '{OP_START,     8'hFF, 6'd63, CHK_SILENT,    NO_BEAT},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_START,     8'h00, 6'd0,  CHK_SILENT,    NO_BEAT},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_PREDICTED, NO_BEAT},
      '{OP_DATA,      8'h0D, 6'd0,  CHK_PREDICTED, NO_BEAT}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mbs_req_if req_ch ();
   mbs_rsp_if rsp_ch ();

   multipart_boundary_stripper_core #(
      .BOUNDARY_DEPTH (STORE_DEPTH),
      .PAGE_SIZE      (PAGE_BYTES),
      .SECTOR_SIZE    (SECTOR_BYTES),
      .ADDRESS_WIDTH  (OUT_ADDR_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state of the stripper.
   logic [DATA_W-1:0]       bnd_chars [STORE_DEPTH];
   bit                      bnd_loaded [STORE_DEPTH];
   int                      match_cnt;
   logic [OUT_ADDR_W-1:0]   flash_addr;
   bit                      armed;
   logic [START_ADDR_W-1:0] cfg_start;
   logic [LENGTH_W-1:0]     cfg_len;

   flash_beat_type flash_due [$];

   bit quiet;
   int errors;
   int items_sent;
   int live_items;
   int beats_checked;
   int parts_ended;
   int replays;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int boundary_span();
      if (cfg_len == 0) return 1;
      if (cfg_len > STORE_DEPTH) return STORE_DEPTH;
      return int'(cfg_len);
   endfunction

   function automatic logic [DATA_W-1:0] any_byte();
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAR_INDEX_W-1:0] any_index();
      return CHAR_INDEX_W'($urandom_range(0, 63));
   endfunction

   function automatic void emit_flash(input logic [DATA_W-1:0] b, input logic fin);
      flash_beat_type beat;
      beat.kind         = KIND_DATA;
      beat.data_byte    = b;
      beat.byte_address = flash_addr;
      beat.sector_first = (flash_addr % SECTOR_BYTES) == 0;
      beat.page_last    = ((flash_addr + 1) % PAGE_BYTES) == 0;
      beat.last         = fin;
      flash_due.push_back(beat);
      flash_addr = flash_addr + 1'b1;
   endfunction

   // Returns 0 when the block ignores the item.
   function automatic bit forecast_flash(input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] val,
                                         input logic [CHAR_INDEX_W-1:0] idx);
      int used;
      int i;
      bit hit;
      flash_beat_type beat;
      if (op == OP_LOAD_CHAR) begin
         bnd_chars[idx]  = val;
         bnd_loaded[idx] = 1'b1;
         return 1'b1;
      end
      if (op == OP_START) begin
         match_cnt  = 0;
         flash_addr = cfg_start;
         armed      = 1'b1;
         return 1'b1;
      end
      if (op != OP_DATA || !armed) return 1'b0;
      used = boundary_span();
      hit = (match_cnt < used) && (val == bnd_chars[match_cnt]);
      if (hit) match_cnt++;
      if (match_cnt >= used) begin
         beat = '{KIND_END, 8'h00, flash_addr, 1'b0, 1'b0, 1'b1};
         flash_due.push_back(beat);
         match_cnt = 0;
         armed     = 1'b0;
         parts_ended++;
      end else if (!hit) begin
         if (match_cnt > 0) replays++;
         for (i = 0; i < match_cnt; i++) emit_flash(bnd_chars[i], 1'b0);
         emit_flash(val, 1'b1);
         match_cnt = 0;
      end
      return 1'b1;
   endfunction

   function automatic string beat_text(input flash_beat_type b);
      return $sformatf("kind=%0d data=%02h addr=%06h sf=%0d pl=%0d last=%0d",
                       b.kind, b.data_byte, b.byte_address, b.sector_first, b.page_last,
                       b.last);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                            input logic [CHAR_INDEX_W-1:0] idx,
                            input logic [1:0] chk = CHK_PREDICTED,
                            input flash_beat_type typed = NO_BEAT);
      int depth0;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.value      <= val;
      req_ch.char_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      depth0 = flash_due.size();
      if (forecast_flash(op, val, idx)) live_items++;
      if (chk != CHK_PREDICTED) begin
         while (flash_due.size() > depth0) void'(flash_due.pop_back());
         if (chk == CHK_TYPED) flash_due.push_back(typed);
      end
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (flash_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == CSR_START_ADDRESS) cfg_start = data[START_ADDR_W-1:0];
      else cfg_len = data[LENGTH_W-1:0];
      @(posedge clock);
   endtask

   task automatic send_prefix(input int k);
      int i;
      for (i = 0; i < k; i++) send_item(OP_DATA, bnd_chars[i], any_index());
   endtask

   task automatic run_part(input logic [START_ADDR_W-1:0] base,
                           input logic [LENGTH_W-1:0] blen, input bit shrink);
      int used;
      int i;
      int k;
      logic [DATA_W-1:0] b;
      settle();
      write_csr(CSR_START_ADDRESS, base);
      write_csr(CSR_BOUNDARY_LENGTH, {{(CSR_DATA_W-LENGTH_W){1'b0}}, blen});
      used = boundary_span();
      for (i = 0; i < used; i++) begin
         if (!bnd_loaded[i] || $urandom_range(0, 3) == 0) begin
            b = any_byte();
            if (i < 4 && $urandom_range(0, 3) != 0) b = CRLF_DASH[31-8*i -: 8];
            send_item(OP_LOAD_CHAR, b, CHAR_INDEX_W'(i));
         end
      end
      send_item(OP_START, any_byte(), any_index());
      repeat ($urandom_range(2, 6)) begin
         if (!armed) send_item(OP_START, any_byte(), any_index());
         case ($urandom_range(0, 7))
            0, 1, 2: begin
               send_item(OP_DATA, any_byte(), any_index());
            end
            3, 4, 5: begin
               k = (used > 1) ? int'($urandom_range(1, used - 1)) : 0;
               send_prefix(k);
               b = any_byte();
               if ($urandom_range(0, 1) == 0) b = bnd_chars[0];
               if (b == bnd_chars[k]) b = b + 1'b1;
               send_item(OP_DATA, b, any_index());
            end
            6: begin
               send_item(OP_UNUSED, any_byte(), any_index());
            end
            default: begin
               send_item(OP_LOAD_CHAR, any_byte(), any_index());
            end
         endcase
      end
      if (shrink && used > 1) begin
         send_item(OP_START, any_byte(), any_index());
         k = int'($urandom_range(1, used - 1));
         send_prefix(k);
         settle();
         write_csr(CSR_BOUNDARY_LENGTH, CSR_DATA_W'($urandom_range(0, k)));
         send_item(OP_DATA, any_byte(), any_index());
      end else if ($urandom_range(0, 4) != 0) begin
         if (!armed) send_item(OP_START, any_byte(), any_index());
         send_prefix(boundary_span());
      end
      if ($urandom_range(0, 2) == 0) begin
         send_item(OP_DATA, any_byte(), any_index());
      end
   endtask

   task automatic run_random_part();
      logic [START_ADDR_W-1:0] base;
      logic [LENGTH_W-1:0] blen;
      base = START_ADDR_W'($urandom);
      if ($urandom_range(0, 1) == 0) base[11:0] = 12'(12'hFFF - $urandom_range(0, 20));
      blen = ($urandom_range(0, 7) == 0) ? LENGTH_W'($urandom_range(0, 1))
                                         : LENGTH_W'($urandom_range(2, 10));
      run_part(base, blen, $urandom_range(0, 5) == 0);
   endtask

   initial begin : rsp_stall
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && !quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      flash_beat_type got;
      flash_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.data_byte, rsp_ch.byte_address, rsp_ch.sector_first,
                 rsp_ch.page_last, rsp_ch.last};
         if (flash_due.size() == 0) begin
            report_mismatch({"unexpected result ", beat_text(got)});
         end else begin
            want = flash_due.pop_front();
            if (got !== want) begin
               report_mismatch({"expected ", beat_text(want), " got ", beat_text(got)});
            end
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  flash_due.size());
         $display("tb_multipart_boundary_stripper_core failed");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_LOAD_CHAR;
      req_ch.value      <= '0;
      req_ch.char_index <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_START_ADDRESS;
      csr_wdata         <= '0;
      foreach (bnd_chars[r]) begin
         bnd_chars[r]  = '0;
         bnd_loaded[r] = 1'b0;
      end
      match_cnt  = 0;
      flash_addr = '0;
      armed      = 1'b0;
      cfg_start  = '0;
      cfg_len    = BOUNDARY_LENGTH_RESET;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         send_item(dir_tab[r].op, dir_tab[r].value, dir_tab[r].char_index, dir_tab[r].chk,
                   dir_tab[r].beat);
      end

      run_part(24'hFFFFFF, 7'd5, 1'b0);
      run_part(24'h000FFE, 7'd0, 1'b0);
      run_part(24'h000FF0, 7'd6, 1'b1);
      while (items_sent < ITEM_TARGET - QUIET_ITEMS) begin
         run_random_part();
      end
      quiet = 1'b1;
      do begin
         run_random_part();
      end while (items_sent < ITEM_TARGET);
      settle();

      $display("Sent %0d items (%0d not ignored), checked %0d results.", items_sent,
               live_items, beats_checked);
      $display("Parts completed: %0d, prefix replays: %0d, mismatches: %0d.", parts_ended,
               replays, errors);
      if (errors == 0) begin
         $display("tb_multipart_boundary_stripper_core passed");
      end else begin
         $display("tb_multipart_boundary_stripper_core failed");
      end
      $finish;
   end

endmodule

// File: multipart_boundary_stripper_core.f
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_req_if.sv
hw/rtl/mbs_rsp_if.sv
hw/rtl/mbs_controller.sv
hw/rtl/mbs_datapath.sv
hw/rtl/multipart_boundary_stripper_core.sv
test/tb_multipart_boundary_stripper_core.sv
